// ----- hdl/range_shift_selector_defines.svh -----
// Assertion macros shared by the range shift selector RTL.
// Bodies sample on clk and stay quiet while rst_n is low.
`ifndef RANGE_SHIFT_SELECTOR_DEFINES_SVH
`define RANGE_SHIFT_SELECTOR_DEFINES_SVH

// Same-cycle implication.
`define RSS_CHECK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RSS_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rss_pkg.sv -----
// Shared types and constants for the range shift selector.
// No dependencies.
package rss_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int MAG_W          = 15;
  localparam int SHIFT_W        = 5;
  localparam int NUM_SHIFTS     = 32;
  localparam int TW_W           = 5;
  localparam int SB_W           = 3;
  localparam int TOL_W          = 15;
  localparam int MAX_SHIFT_BITS = 5;

  localparam logic [TW_W-1:0] FULL_WIDTH = 5'd16;

  typedef logic [MAG_W-1:0]          mag_t;
  typedef mag_t [NUM_SHIFTS-1:0]     err_vec_t;
  typedef logic signed [SHIFT_W-1:0] shift_t;

  typedef enum logic [1:0] {
    REG_CUR_PREC   = 2'd0,
    REG_TGT_WIDTH  = 2'd1,
    REG_SHIFT_BITS = 2'd2,
    REG_ERR_TOL    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [TW_W-1:0]  target_width;
    logic [SB_W-1:0]  shift_bits;
    logic [TOL_W-1:0] error_tolerance;
  } cfg_t;

  typedef struct packed {
    shift_t shift;
    logic   keep_prev;
  } pick_res_t;

endpackage

// ----- hdl/rss_err.sv -----
// Error of every possible shift for one sample, all lanes in parallel.
// Depends on rss_pkg.
module rss_err (
  input  logic signed [rss_pkg::SAMPLE_W-1:0] sample,
  input  logic [rss_pkg::TW_W-1:0]            target_width,
  output rss_pkg::err_vec_t                   err
);
  import rss_pkg::*;

  // Magnitude kept at conversion shift c under the width mask.
  function automatic mag_t kept_value(input mag_t mag, input logic signed [6:0] c,
                                      input logic [15:0] mask);
    logic signed [6:0] neg;
    logic [15:0]       lo;
    mag_t              res;
    neg = -c;
    lo  = '0;
    res = '0;
    if (c > 7'sd0) begin
      if (c >= 7'sd15) begin
        res = '0;
      end else begin
        res = ((mag >> c[3:0]) & mask[MAG_W-1:0]) << c[3:0];
      end
    end else begin
      if (neg >= 7'sd16) begin
        res = '0;
      end else begin
        lo  = ({1'b0, mag} << neg[3:0]) & mask;
        res = MAG_W'(lo >> neg[3:0]);
      end
    end
    return res;
  endfunction

  mag_t                mag;
  logic [15:0]         mask;
  logic signed [6:0]   base;

  always_comb begin
    // Saturate the most negative sample to full scale.
    if (sample == -16'sd32768) begin
      mag = 15'h7FFF;
    end else if (sample < 0) begin
      mag = MAG_W'(-sample);
    end else begin
      mag = MAG_W'(sample);
    end
  end

  always_comb begin
    if (target_width == '0) begin
      mask = '0;
    end else if (target_width > FULL_WIDTH) begin
      mask = 16'hFFFF;
    end else begin
      mask = 16'((17'd1 << (target_width - 5'd1)) - 17'd1);
    end
  end

  assign base = 7'sd16 - $signed({2'b00, target_width});

  // Lane i evaluates shift i-16.
  always_comb begin
    for (int i = 0; i < NUM_SHIFTS; i++) begin
      err[i] = mag - kept_value(mag, base + $signed(7'(i)) - 7'sd16, mask);
    end
  end

endmodule

// ----- hdl/rss_pick.sv -----
// Minimum search over the allowed shifts and final choice against the previous shift.
// Depends on rss_pkg.
module rss_pick (
  input  rss_pkg::err_vec_t  err,
  input  rss_pkg::shift_t    prev,
  input  rss_pkg::cfg_t      cfg,
  output rss_pkg::pick_res_t res
);
  import rss_pkg::*;

  logic [SB_W-1:0]   nb;
  logic signed [6:0] half;
  logic signed [6:0] lo_b;
  logic signed [6:0] hi_b;
  logic [MAG_W:0]    key [NUM_SHIFTS];
  logic [4:0]        idx [NUM_SHIFTS];
  mag_t              perr;
  mag_t              min_err;
  logic              keep;

  always_comb begin
    if (cfg.shift_bits == '0) begin
      nb = SB_W'(1);
    end else if (cfg.shift_bits > SB_W'(MAX_SHIFT_BITS)) begin
      nb = SB_W'(MAX_SHIFT_BITS);
    end else begin
      nb = cfg.shift_bits;
    end
  end

  assign half = $signed(7'(1) << (nb - SB_W'(1)));
  assign lo_b = -half;
  assign hi_b = half - 7'sd1;

  // Pairwise tree, lower shift on the left so ties go to the lower shift.
  always_comb begin
    logic signed [6:0] si;
    si = '0;
    for (int i = 0; i < NUM_SHIFTS; i++) begin
      si     = $signed(7'(i)) - 7'sd16;
      key[i] = {!((si >= lo_b) && (si <= hi_b)), err[i]};
      idx[i] = 5'(i);
    end
    for (int lv = 0; lv < 5; lv++) begin
      for (int j = 0; j < NUM_SHIFTS / 2; j++) begin
        if (j < (NUM_SHIFTS >> (lv + 1))) begin
          if (key[2*j] <= key[2*j+1]) begin
            key[j] = key[2*j];
            idx[j] = idx[2*j];
          end else begin
            key[j] = key[2*j+1];
            idx[j] = idx[2*j+1];
          end
        end
      end
    end
  end

  assign min_err = key[0][MAG_W-1:0];
  assign perr    = err[{~prev[4], prev[3:0]}];
  assign keep    = (perr <= cfg.error_tolerance) || (perr <= min_err);

  always_comb begin
    res.keep_prev = 1'b0;
    if (cfg.target_width == FULL_WIDTH) begin
      res.shift = '0;
    end else if (keep) begin
      res.shift     = prev;
      res.keep_prev = 1'b1;
    end else begin
      // Lane index back to the shift code: flip the sign bit.
      res.shift = $signed(idx[0] ^ 5'b10000);
    end
  end

endmodule

// ----- hdl/range_shift_selector.sv -----
// Top level of the range shift selector: handshakes, configuration, pipeline registers.
// Depends on rss_pkg, rss_err, rss_pick and range_shift_selector_defines.svh.
//
//   channel | dir | handshake              | payload
//   in      | in  | in_tvalid / in_tready  | tdata: sample; tuser: block_start
//   out     | out | out_tvalid / out_tready| tdata: chosen_shift (zero padded)
//   cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle sustained while out_tready stays high; out_tvalid rises once the item has
// passed the error stage register and then the output register; a stall can hold it in between.
// The error stage register holds all 32 lane errors; the output stage resolves the
// minimum and compares it with the previous shift, which feeds back through last_shift_r.
// Reset (rst_n low, synchronous) empties both stages, clears the previous shift and
// loads the register defaults. Output stalls back up through the error stage only.
module range_shift_selector (
  input  logic        clk,
  input  logic        rst_n,
  // in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tuser,   // [0] block_start
  // out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [4:0] chosen_shift, [7:5] zero
  // cfg
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);
  import rss_pkg::*;
  `include "range_shift_selector_defines.svh"

  cfg_t      cfg_r;
  err_vec_t  err_in;
  err_vec_t  err_r;
  logic      bstart_r;
  logic      v1_r;
  logic      v1_nxt;
  logic      out_valid_r;
  logic      out_valid_nxt;
  shift_t    chosen_r;
  shift_t    last_shift_r;
  shift_t    prev_shift;
  pick_res_t pick;
  logic      in_fire;
  logic      adv;
  logic      s1_fire;

  // Configuration is always taken; the host must write only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_width    <= TW_W'(8);
      cfg_r.shift_bits      <= SB_W'(3);
      cfg_r.error_tolerance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        REG_CUR_PREC:   ; // fractional bits cancel out of the shift rule: drop
        REG_TGT_WIDTH:  cfg_r.target_width    <= cfg_data[TW_W-1:0];
        REG_SHIFT_BITS: cfg_r.shift_bits      <= cfg_data[SB_W-1:0];
        REG_ERR_TOL:    cfg_r.error_tolerance <= cfg_data[TOL_W-1:0];
        default:        ;
      endcase
    end
  end

  // Output register free, or emptied by a transfer this cycle: advance.
  assign adv       = !out_valid_r || out_tready;
  assign s1_fire   = v1_r && adv;
  assign in_tready = !v1_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  // Stage one: every lane error straight off the input transfer.
  rss_err u_err (
    .sample       ($signed(in_tdata)),
    .target_width (cfg_r.target_width),
    .err          (err_in)
  );

  always_comb begin
    if (in_fire) begin
      v1_nxt = 1'b1;
    end else if (adv) begin
      v1_nxt = 1'b0;
    end else begin
      v1_nxt = v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  // Hold payload until it moves on.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      err_r    <= err_in;
      bstart_r <= in_tuser;
    end
  end

  // Stage two: block start forces the previous shift to zero.
  assign prev_shift = bstart_r ? shift_t'(0) : last_shift_r;

  rss_pick u_pick (
    .err  (err_r),
    .prev (prev_shift),
    .cfg  (cfg_r),
    .res  (pick)
  );

  always_comb begin
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      last_shift_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        last_shift_r <= pick.shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      chosen_r <= pick.shift;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, chosen_r};

  `RSS_CHECK_NOW(a_last_tracks_out, out_valid_r, last_shift_r == chosen_r, "previous shift differs from the shown result")
  `RSS_CHECK_NOW(a_stall_only_full, !in_tready, v1_r && out_valid_r, "input stalled with a free stage")
  `RSS_CHECK_NEXT(a_full_width_zero, s1_fire && (cfg_r.target_width == FULL_WIDTH), chosen_r == shift_t'(0), "full width gave a nonzero shift")
  `RSS_CHECK_NEXT(a_keep_prev, s1_fire && pick.keep_prev, chosen_r == $past(prev_shift), "kept shift is not the previous one")

endmodule
